### src/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants
// Frame byte positions, CRC-8 update, error codes and scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  // Byte positions inside one measurement frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scaling: value = floor(SPAN * raw / FULL_SCALE), temperature less offset
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BUS      = 2'd1,
    ERR_TEMP_CRC = 2'd2,
    ERR_HUM_CRC  = 2'd3
  } err_code_t;

  // One finished frame, handed from the front end to the scaler
  typedef struct packed {
    err_code_t   code;
    logic [15:0] temp_word;
    logic [15:0] hum_raw;
  } frame_rec_t;

  // One result as it leaves the scaler
  typedef struct packed {
    err_code_t          code;
    logic               valid_res;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
  } result_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### src/sensor_frame_crc_check_and_scale.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_and_scale: sensor frame checker and scaler
// Checks the two CRC-8 words of a six-byte temperature/humidity frame and
// scales the raw words to hundredths of a degree and of a percent.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Item                      Fields (low bit up)
// s_*       in   one received frame byte   tdata: rx_byte[7:0]
//                                          tuser: first_of_frame, bus_error
// m_*       out  one frame result          tdata: temperature_centi[14:0],
//                                                 humidity_centi[13:0], pad
//                                          tuser: valid_res, error_code[1:0]
//
// Takes one byte per cycle. s_tready drops only while the record queue is full.
// Once the byte that closes a frame (or a bus error) is accepted, the result
// passes through the record queue and the product register of the scaler into
// the output register, where it shows on m_* and waits until taken.
// rst (synchronous) restarts the frame tracker and empties queue and pipeline.
// A stall on m_* backs up the scaler, then the queue, then s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_crc_check_and_scale
  import sfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  wire logic [1:0]  s_tuser,   // [0] first_of_frame, [1] bus_error
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [14:0] temperature_centi,
                                      // [28:15] humidity_centi, [31:29] zero
  output logic [2:0]       m_tuser    // [0] valid_res, [2:1] error_code
);

  logic       push;
  frame_rec_t push_rec;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  frame_rec_t q_head;
  result_t    res;

  // Front: track position and CRC, classify each finished frame
  sfc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .rx_byte        (s_tdata),
    .first_of_frame (s_tuser[0]),
    .bus_error      (s_tuser[1]),
    .q_full         (q_full),
    .push           (push),
    .rec            (push_rec)
  );

  // Hold finished frames while the scaler or the sink stalls
  sfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: scale raw words and drive the output register
  sfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_not_empty),
    .rec_pop   (q_pop),
    .rec       (q_head),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {3'b000, res.humidity_centi, res.temperature_centi};
  assign m_tuser = {res.code, res.valid_res};

`ifndef NO_ASSERTIONS
  // A valid result always carries the ok code
  a_valid_code_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ERR_NONE))
    else $error("valid result with nonzero error code");

  // An invalid result carries zero values
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
    else $error("invalid result with nonzero values");

  // Scaled temperature stays in the sensor range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      ($signed(m_tdata[14:0]) >= -15'sd4500 && $signed(m_tdata[14:0]) <= 15'sd13000))
    else $error("temperature out of range");
`endif

endmodule

`default_nettype wire

### src/sfc_front.sv
// ----------------------------------------------------------------------------
// sfc_front: frame tracker
// Follows the byte position, runs the CRC, records each frame and bus error.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_front
  import sfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       first_of_frame,
  input  wire logic       bus_error,
  input  wire logic       q_full,
  output logic            push,
  output frame_rec_t      rec
);

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic        temperature_crc_good, temperature_crc_good_next;
  logic [15:0] temperature_word, temperature_word_next;
  logic [15:0] humidity_word, humidity_word_next;

  logic       take;
  logic [2:0] pos;
  logic [7:0] crc_in;
  logic       tgood_in;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    pos      = (first_of_frame || byte_position > POS_H_CRC) ? POS_T_MSB : byte_position;
    crc_in   = (pos == POS_T_MSB) ? CRC_INIT : running_crc;
    tgood_in = (pos == POS_T_MSB) ? 1'b0 : temperature_crc_good;

    byte_position_next        = byte_position;
    running_crc_next          = running_crc;
    temperature_crc_good_next = temperature_crc_good;
    temperature_word_next     = temperature_word;
    humidity_word_next        = humidity_word;
    push                      = 1'b0;
    rec.code                  = ERR_NONE;
    rec.temp_word             = temperature_word;
    rec.hum_raw               = humidity_word;

    if (take) begin
      if (bus_error) begin
        // drop the byte, restart the frame, report
        byte_position_next        = POS_T_MSB;
        running_crc_next          = CRC_INIT;
        temperature_crc_good_next = 1'b0;
        push                      = 1'b1;
        rec.code                  = ERR_BUS;
      end else begin
        byte_position_next        = pos + 3'd1;
        running_crc_next          = crc_in;
        temperature_crc_good_next = tgood_in;
        case (pos)
          POS_T_MSB: begin
            temperature_word_next[15:8] = rx_byte;
            running_crc_next            = crc8_feed(crc_in, rx_byte);
          end
          POS_T_LSB: begin
            temperature_word_next[7:0] = rx_byte;
            running_crc_next           = crc8_feed(crc_in, rx_byte);
          end
          POS_T_CRC: begin
            temperature_crc_good_next = (crc_in == rx_byte);
            running_crc_next          = CRC_INIT;
          end
          POS_H_MSB: begin
            humidity_word_next[15:8] = rx_byte;
            running_crc_next         = crc8_feed(crc_in, rx_byte);
          end
          POS_H_LSB: begin
            humidity_word_next[7:0] = rx_byte;
            running_crc_next        = crc8_feed(crc_in, rx_byte);
          end
          default: begin
            byte_position_next        = POS_T_MSB;
            running_crc_next          = CRC_INIT;
            temperature_crc_good_next = 1'b0;
            push                      = 1'b1;
            if (!tgood_in) begin
              rec.code = ERR_TEMP_CRC;
            end else if (crc_in != rx_byte) begin
              rec.code = ERR_HUM_CRC;
            end else begin
              rec.code = ERR_NONE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= POS_T_MSB;
      running_crc          <= CRC_INIT;
      temperature_crc_good <= 1'b0;
    end else begin
      byte_position        <= byte_position_next;
      running_crc          <= running_crc_next;
      temperature_crc_good <= temperature_crc_good_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_word <= '0;
      humidity_word    <= '0;
    end else begin
      temperature_word <= temperature_word_next;
      humidity_word    <= humidity_word_next;
    end
  end

endmodule

`default_nettype wire

### src/sfc_queue.sv
// ----------------------------------------------------------------------------
// sfc_queue: frame record queue
// Small FIFO between the frame tracker and the scaler; depth a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_queue
  import sfc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output frame_rec_t      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_rec_t     entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

`default_nettype wire

### src/sfc_back.sv
// ----------------------------------------------------------------------------
// sfc_back: scaler
// Multiplies the raw words by their spans, divides by full scale, registers out.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_back
  import sfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rec_valid,
  output logic            rec_pop,
  input  wire frame_rec_t rec,
  output logic            res_valid,
  input  wire logic       res_ready,
  output result_t         res
);

  // product stage
  logic        prod_valid;
  err_code_t   prod_code;
  logic [30:0] prod_t;
  logic [29:0] prod_h;

  logic        out_load;

  logic [14:0] tq0, tq;
  logic [16:0] tr0;
  logic [13:0] hq0, hq;
  logic [16:0] hr0;
  result_t     res_next;

  assign out_load = prod_valid && (!res_valid || res_ready);
  assign rec_pop  = rec_valid && (!prod_valid || out_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (rec_pop) begin
      prod_valid <= 1'b1;
    end else if (out_load) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      prod_code <= rec.code;
      prod_t    <= 31'(rec.temp_word) * 31'(TEMP_SPAN);
      prod_h    <= 30'(rec.hum_raw) * 30'(HUM_SPAN);
    end
  end

  // p = q0*65536 + lo = q0*65535 + (lo + q0); the remainder stays below twice
  // full scale, so one compare corrects the quotient
  always_comb begin
    tq0 = prod_t[30:16];
    tr0 = {1'b0, prod_t[15:0]} + 17'(tq0);
    tq  = tq0 + 15'(tr0 >= FULL_SCALE);
    hq0 = prod_h[29:16];
    hr0 = {1'b0, prod_h[15:0]} + 17'(hq0);
    hq  = hq0 + 14'(hr0 >= FULL_SCALE);

    res_next.code = prod_code;
    if (prod_code == ERR_NONE) begin
      res_next.valid_res         = 1'b1;
      res_next.temperature_centi = $signed(tq - TEMP_OFFSET);
      res_next.humidity_centi    = hq;
    end else begin
      res_next.valid_res         = 1'b0;
      res_next.temperature_centi = '0;
      res_next.humidity_centi    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

### sim/sensor_frame_crc_check_and_scale_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_and_scale_tb: self-checking bench for the frame checker
// Feeds six-byte temperature/humidity frames and stray bytes on s_*, predicts
// each result with its own frame tracker and CRC-8, and compares every m_*
// item field by field. A directed table comes first, then random frames
// under four sender-idle / receiver-stall mixes.
// ----------------------------------------------------------------------------

module sensor_frame_crc_check_and_scale_tb;
  import sfc_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int QUIET_LIMIT  = 5000;   // cycles with no item moving on either side
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 8;      // wait for stray results before judging
  localparam int NUM_PHASES   = 4;

  // How the byte of a stimulus row is formed
  typedef enum logic [1:0] {
    ROW_BYTE,       // data as given
    ROW_CRC_GOOD,   // CRC-8 of the two bytes sent just before
    ROW_CRC_BAD     // inverted CRC-8 of the two bytes sent just before
  } row_kind_t;

  typedef struct packed {
    logic [7:0]         data;
    row_kind_t          kind;
    logic               first;
    logic               berr;
    logic               typed;       // expectation typed in below
    logic signed [14:0] want_temp;
    logic [13:0]        want_hum;
    logic               want_valid;
    err_code_t          want_code;
  } stim_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;    // rx_byte[7:0]
  logic [1:0]  s_tuser  = '0;    // [0] first_of_frame, [1] bus_error
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [14:0] temperature_centi, [28:15] humidity_centi
  logic [2:0]  m_tuser;          // [0] valid_res, [2:1] error_code

  // Typed expectation travels beside the byte so the monitor sees both at once
  logic        row_typed = 1'b0;
  result_t     row_want  = '0;

  sensor_frame_crc_check_and_scale dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Frame tracker state mirrored from the block
  logic [2:0]  trk_pos;
  logic [7:0]  trk_crc;
  logic [15:0] trk_temp;
  logic [15:0] trk_hum;
  logic        trk_temp_ok;

  result_t     pending_readings[$];   // results still owed by the block
  int          mismatch_count     = 0;
  int          results_seen       = 0;
  int          quiet_cycles       = 0;
  int          items_sent         = 0;
  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  logic [7:0]  sent_hi            = '0;
  logic [7:0]  sent_lo            = '0;
  logic        resync_due         = 1'b0;

  stim_row_t   directed_rows [27];

  initial begin
    forever #1 clk = ~clk;
  end

  // CRC-8, polynomial 0x31, MSB first, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advance the frame tracker by one accepted byte; flag and fill a result
  // when the byte closes a frame or reports a bus error.
  task automatic track_frame_byte(input logic [7:0] b, input logic first, input logic berr,
                                  output logic emits, output result_t res);
    logic [2:0]  pos;
    logic [31:0] tq;
    logic [31:0] hq;
    logic        hum_ok;
    emits = 1'b0;
    res   = '0;
    if (berr) begin
      // Drop the byte and restart the frame
      trk_pos     = POS_T_MSB;
      trk_crc     = CRC_INIT;
      trk_temp_ok = 1'b0;
      res.code    = ERR_BUS;
      emits       = 1'b1;
      return;
    end
    pos = (first || trk_pos > POS_H_CRC) ? POS_T_MSB : trk_pos;
    if (pos == POS_T_MSB) begin
      trk_crc     = CRC_INIT;
      trk_temp_ok = 1'b0;
    end
    case (pos)
      POS_T_MSB: begin
        trk_temp[15:8] = b;
        trk_crc        = crc8_step(trk_crc, b);
      end
      POS_T_LSB: begin
        trk_temp[7:0] = b;
        trk_crc       = crc8_step(trk_crc, b);
      end
      POS_T_CRC: begin
        trk_temp_ok = (trk_crc == b);
        trk_crc     = CRC_INIT;
      end
      POS_H_MSB: begin
        trk_hum[15:8] = b;
        trk_crc       = crc8_step(trk_crc, b);
      end
      POS_H_LSB: begin
        trk_hum[7:0] = b;
        trk_crc      = crc8_step(trk_crc, b);
      end
      default: begin
        hum_ok = (trk_crc == b);
        emits  = 1'b1;
        // Temperature is judged first when both words are bad
        if (!trk_temp_ok) begin
          res.code = ERR_TEMP_CRC;
        end else if (!hum_ok) begin
          res.code = ERR_HUM_CRC;
        end else begin
          tq = (32'(TEMP_SPAN) * 32'(trk_temp)) / 32'(FULL_SCALE);
          hq = (32'(HUM_SPAN) * 32'(trk_hum)) / 32'(FULL_SCALE);
          res.temperature_centi = 15'(tq - 32'(TEMP_OFFSET));
          res.humidity_centi    = 14'(hq);
          res.valid_res         = 1'b1;
          res.code              = ERR_NONE;
        end
        trk_pos     = POS_T_MSB;
        trk_crc     = CRC_INIT;
        trk_temp_ok = 1'b0;
      end
    endcase
    if (!emits) begin
      trk_pos = pos + 3'd1;
    end
  endtask

  // Monitor: predict on every accepted byte, check every accepted result.
  // Both sides are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin : monitor
    logic    emits;
    result_t predicted;
    result_t want;
    result_t got;
    m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    if (rst) begin
      trk_pos      = POS_T_MSB;
      trk_crc      = CRC_INIT;
      trk_temp     = '0;
      trk_hum      = '0;
      trk_temp_ok  = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_frame_byte(s_tdata, s_tuser[0], s_tuser[1], emits, predicted);
        // Prefer the hand-typed value on rows that carry one
        if (emits) begin
          pending_readings.push_back(row_typed ? row_want : predicted);
        end
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.temperature_centi = m_tdata[14:0];
        got.humidity_centi    = m_tdata[28:15];
        got.valid_res         = m_tuser[0];
        got.code              = err_code_t'(m_tuser[2:1]);
        if (pending_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("result %0d: none expected, got T=%0d H=%0d valid=%0b code=%0d",
                     results_seen, got.temperature_centi, got.humidity_centi,
                     got.valid_res, got.code);
          end
        end else begin
          want = pending_readings.pop_front();
          if (got.temperature_centi !== want.temperature_centi ||
              got.humidity_centi !== want.humidity_centi ||
              got.valid_res !== want.valid_res || got.code !== want.code) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("result %0d: expected T=%0d H=%0d valid=%0b code=%0d", results_seen,
                       want.temperature_centi, want.humidity_centi, want.valid_res,
                       want.code);
              $display("result %0d: actual   T=%0d H=%0d valid=%0b code=%0d", results_seen,
                       got.temperature_centi, got.humidity_centi, got.valid_res, got.code);
            end
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Drive one byte, idling first at the current rate, and hold it until taken.
  // Leave s_tvalid high on return so back-to-back bytes need no gap.
  task automatic send_byte(input stim_row_t row);
    logic [7:0] b;
    result_t    want;
    b = row.data;
    if (row.kind != ROW_BYTE) begin
      b = word_crc({sent_hi, sent_lo});
      if (row.kind == ROW_CRC_BAD) begin
        b = ~b;
      end
    end
    want.temperature_centi = row.want_temp;
    want.humidity_centi    = row.want_hum;
    want.valid_res         = row.want_valid;
    want.code              = row.want_code;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= b;
    s_tuser   <= {row.berr, row.first};
    row_typed <= row.typed;
    row_want  <= want;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    sent_hi = sent_lo;
    sent_lo = b;
  endtask

  // Lower valid and hold off until every owed result has come back
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  // Bias raw words toward the scale ends now and then
  function automatic logic [15:0] pick_raw_word();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One frame with random content: mostly well formed, sometimes with a bad
  // CRC, a stray frame mark, a bus error or a cut-off tail.
  task automatic send_random_frame();
    logic [15:0] tw;
    logic [15:0] hw;
    logic [7:0]  frame_bytes [6];
    stim_row_t   row;
    int          cut;
    int          err_at;
    int          pick;
    tw = pick_raw_word();
    hw = pick_raw_word();
    frame_bytes[0] = tw[15:8];
    frame_bytes[1] = tw[7:0];
    frame_bytes[2] = word_crc(tw);
    frame_bytes[3] = hw[15:8];
    frame_bytes[4] = hw[7:0];
    frame_bytes[5] = word_crc(hw);
    if ($urandom_range(0, 99) < 12) begin
      frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(1, 255));
    end
    if ($urandom_range(0, 99) < 12) begin
      frame_bytes[5] = frame_bytes[5] ^ 8'($urandom_range(1, 255));
    end
    cut    = 6;
    err_at = -1;
    pick   = $urandom_range(0, 99);
    if (pick < 5) begin
      cut = $urandom_range(1, 5);
    end else if (pick < 11) begin
      err_at = $urandom_range(0, 5);
    end
    for (int i = 0; i < cut; i++) begin
      row       = '0;
      row.kind  = ROW_BYTE;
      row.data  = frame_bytes[i];
      // Mark the start at random; force it after a cut-off frame
      row.first = (i == 0) ? (resync_due || $urandom_range(0, 1) == 1)
                           : ($urandom_range(0, 49) == 0);
      row.berr  = (i == err_at);
      send_byte(row);
      if (row.berr) begin
        break;
      end
    end
    resync_due = (cut < 6);
  endtask

  initial begin
    int phase_end;

    // Directed frames: scale ends, bus error, both CRC faults, resync
    directed_rows = '{
      // all-zero words: lowest temperature and humidity
      '{8'h00, ROW_BYTE,     1'b1, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_CRC_GOOD, 1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_CRC_GOOD, 1'b0, 1'b0, 1'b1, -15'sd4500, 14'd0,     1'b1, ERR_NONE},
      // all-ones words, no start mark after a finished frame: highest values
      '{8'hFF, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'hFF, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_CRC_GOOD, 1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'hFF, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'hFF, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_CRC_GOOD, 1'b0, 1'b0, 1'b1, 15'sd13000,  14'd10000, 1'b1, ERR_NONE},
      // bus error mid-frame, with the start mark also set
      '{8'h3C, ROW_BYTE,     1'b1, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'hFF, ROW_BYTE,     1'b1, 1'b1, 1'b1, 15'sd0,     14'd0,     1'b0, ERR_BUS},
      // both CRCs bad: temperature wins
      '{8'h12, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h34, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_CRC_BAD,  1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h56, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h78, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_CRC_BAD,  1'b0, 1'b0, 1'b1, 15'sd0,     14'd0,     1'b0, ERR_TEMP_CRC},
      // partial frame dropped by a new start mark, then humidity CRC bad
      '{8'h80, ROW_BYTE,     1'b1, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h01, ROW_BYTE,     1'b1, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h02, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_CRC_GOOD, 1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'hAB, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'hCD, ROW_BYTE,     1'b0, 1'b0, 1'b0, 15'sd0,     14'd0,     1'b0, ERR_NONE},
      '{8'h00, ROW_CRC_BAD,  1'b0, 1'b0, 1'b1, 15'sd0,     14'd0,     1'b0, ERR_HUM_CRC}
    };

    // Hold reset, then release it once
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i]);
    end
    // Pause the sender until every directed result is back
    hold_until_drained();

    // Random frames: no idling, sender idle, receiver stall, then both
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 83;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 83;
        end
        default: begin
          sender_idle_pct    = 31;
          receiver_stall_pct = 31;
        end
      endcase
      phase_end = items_sent + ITEM_TARGET / NUM_PHASES;
      while (items_sent < phase_end) begin
        send_random_frame();
      end
      hold_until_drained();
    end

    // Let any stray result show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
src/sfc_pkg.sv
src/sfc_front.sv
src/sfc_queue.sv
src/sfc_back.sv
src/sensor_frame_crc_check_and_scale.sv
sim/sensor_frame_crc_check_and_scale_tb.sv
